/* design/rgbpwm_pkg.sv */
`timescale 1ns / 1ps

package rgbpwm_pkg;

   // Panel geometry
   localparam int PANEL_COLUMNS = 64;
   localparam int HALF_ROWS     = 16;
   localparam int PANEL_ROWS    = 2 * HALF_ROWS;

   localparam int COL_W = $clog2(PANEL_COLUMNS);
   localparam int ROW_W = $clog2(HALF_ROWS);

   // Each half of the panel has its own store, addressed {row, column}
   localparam int STORE_ADDR_W     = ROW_W + COL_W;
   localparam int STORE_HALF_DEPTH = 2 ** STORE_ADDR_W;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(PANEL_COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(HALF_ROWS - 1);

   // Item field widths
   localparam int PIX_X_W     = 6;
   localparam int PIX_Y_W     = 5;
   localparam int COLOR_W     = 12;
   localparam int COMP_W      = 4;
   localparam int COLUMN_IDX_W = 6;
   localparam int ROW_IDX_W   = 4;
   localparam int LAYER_W     = 4;

   localparam logic [LAYER_W-1:0] LAYER_MAX = LAYER_W'(14);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // Request kinds carried on req_tuser
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_SCAN  = 1'b1;

   typedef struct packed {
      logic clear_en;    // write zero at the sweep address
      logic write_en;    // store the accepted pixel
      logic scan_issue;  // read the current column of both halves
   } cmd_type;

   typedef struct packed {
      logic clear_last;  // sweep address is at the top of the store
      logic slot_free;   // read stage can take a new column
      logic col_last;    // current column is the last of the row
   } status_type;

endpackage

/* design/rgb_matrix_pwm_scan_driver_core.sv */
`timescale 1ns / 1ps
// Write item: accepted with no result; the next item may follow at once.
// Scan item: 64 column words, one per cycle from the two half-panel store reads;
// first word via store read and output registers; next item taken after the 64th read.
// A sink stall holds the read stage and stretches the scan.
// Reset (synchronous, active high) zeroes row, layer and the handshake, then runs a
// clearing pass over all 1024 addresses of each frame store half with req_tready low.
module rgb_matrix_pwm_scan_driver_core (
   input  logic                                  clock,
   input  logic                                  reset,

   // Request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [5:0] pix_x, [10:6] pix_y, [22:11] pix_color, [23] zero
   input  logic [rgbpwm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] req_type: 0 writes one pixel, 1 scans the next row pair
   input  logic                                  req_tuser,

   // Result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] upper_red, [1] upper_green, [2] upper_blue, [3] lower_red,
   // [4] lower_green, [5] lower_blue, [11:6] column_index, [15:12] row_index,
   // [19:16] pwm_layer, [23:20] zero
   output logic [rgbpwm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // latch_pulse: set on the last column word of a row pair
   output logic                                  rsp_tlast
);

   rgbpwm_pkg::cmd_type    cmd;
   rgbpwm_pkg::status_type status;

   logic [rgbpwm_pkg::PIX_X_W-1:0] pix_x;
   logic [rgbpwm_pkg::PIX_Y_W-1:0] pix_y;
   logic [rgbpwm_pkg::COLOR_W-1:0] pix_color;

   // Unpack the request item
   assign pix_x     = req_tdata[5:0];
   assign pix_y     = req_tdata[10:6];
   assign pix_color = req_tdata[22:11];

   // Sequencer: clearing pass, item acceptance, column read issue
   rgbpwm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Frame store halves, scan counters, layer compare and output register
   rgbpwm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .pix_x      (pix_x),
      .pix_y      (pix_y),
      .pix_color  (pix_color),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* design/rgbpwm_ram.sv */
`timescale 1ns / 1ps

module rgbpwm_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rgbpwm_ctrl.sv */
`timescale 1ns / 1ps

module rgbpwm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tuser,
   output logic                   req_tready,
   input  rgbpwm_pkg::status_type status,
   output rgbpwm_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      accept;

   assign accept = req_tvalid && ready_ff;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == rgbpwm_pkg::REQ_SCAN) begin
                  state_in = ST_SCAN;
                  ready_in = 1'b0;
               end else begin
                  cmd.write_en = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = status.slot_free;
            if (status.slot_free && status.col_last) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            ready_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

/* design/rgbpwm_dp.sv */
`timescale 1ns / 1ps

module rgbpwm_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rgbpwm_pkg::cmd_type                   cmd,
   output rgbpwm_pkg::status_type                status,
   input  logic [rgbpwm_pkg::PIX_X_W-1:0]        pix_x,
   input  logic [rgbpwm_pkg::PIX_Y_W-1:0]        pix_y,
   input  logic [rgbpwm_pkg::COLOR_W-1:0]        pix_color,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rgbpwm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int AW = rgbpwm_pkg::STORE_ADDR_W;
   localparam int CW = rgbpwm_pkg::COL_W;
   localparam int RW = rgbpwm_pkg::ROW_W;
   localparam int LW = rgbpwm_pkg::LAYER_W;
   localparam int KW = rgbpwm_pkg::COLOR_W;

   // Sweep, scan position and layer
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [LW-1:0] layer_ff, layer_in;

   // Read stage: side data that travels with the RAM read register
   logic          rd_valid_ff, rd_valid_in;
   logic [CW-1:0] rd_col_ff;
   logic [RW-1:0] rd_row_ff;
   logic [LW-1:0] rd_layer_ff;
   logic          rd_last_ff;

   // Output register
   logic                                  out_valid_ff, out_valid_in;
   logic [rgbpwm_pkg::RSP_DATA_W-1:0]     out_data_ff;
   logic                                  out_last_ff;

   logic          advance;
   logic          slot_free;

   // Pixel write decode
   logic [31:0]   x_ext, y_ext, wrow_ext;
   logic          in_range, upper_half;
   logic [AW-1:0] pix_addr;

   logic          up_we, lo_we;
   logic [AW-1:0] wr_addr;
   logic [KW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [KW-1:0] up_color, lo_color;

   logic [31:0]   col_wide, row_wide;
   logic [rgbpwm_pkg::RSP_DATA_W-1:0] word;

   assign x_ext      = 32'(pix_x);
   assign y_ext      = 32'(pix_y);
   assign in_range   = (x_ext < 32'(rgbpwm_pkg::PANEL_COLUMNS)) &&
                       (y_ext < 32'(rgbpwm_pkg::PANEL_ROWS));
   assign upper_half = y_ext < 32'(rgbpwm_pkg::HALF_ROWS);
   assign wrow_ext   = upper_half ? y_ext : (y_ext - 32'(rgbpwm_pkg::HALF_ROWS));
   assign pix_addr   = {wrow_ext[RW-1:0], x_ext[CW-1:0]};

   assign up_we   = cmd.clear_en || (cmd.write_en && in_range && upper_half);
   assign lo_we   = cmd.clear_en || (cmd.write_en && in_range && !upper_half);
   assign wr_addr = cmd.clear_en ? clr_addr_ff : pix_addr;
   assign wr_data = cmd.clear_en ? '0 : pix_color;
   assign rd_addr = {row_ff, col_ff};

   rgbpwm_ram #(
      .WIDTH (KW),
      .DEPTH (rgbpwm_pkg::STORE_HALF_DEPTH)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (up_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.scan_issue),
      .rd_addr (rd_addr),
      .rd_data (up_color)
   );

   rgbpwm_ram #(
      .WIDTH (KW),
      .DEPTH (rgbpwm_pkg::STORE_HALF_DEPTH)
   ) u_lower_ram (
      .clock   (clock),
      .wr_en   (lo_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.scan_issue),
      .rd_addr (rd_addr),
      .rd_data (lo_color)
   );

   assign advance   = !out_valid_ff || rsp_tready;
   assign slot_free = !rd_valid_ff || advance;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      layer_in    = layer_ff;
      if (cmd.clear_en) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end
      if (cmd.scan_issue) begin
         if (col_ff == rgbpwm_pkg::COL_LAST) begin
            col_in = '0;
            if (row_ff == rgbpwm_pkg::ROW_LAST) begin
               row_in   = '0;
               layer_in = (layer_ff >= rgbpwm_pkg::LAYER_MAX) ? '0 : layer_ff + LW'(1);
            end else begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_comb begin
      if (cmd.scan_issue) begin
         rd_valid_in = 1'b1;
      end else if (advance) begin
         rd_valid_in = 1'b0;
      end else begin
         rd_valid_in = rd_valid_ff;
      end
      out_valid_in = advance ? rd_valid_ff : out_valid_ff;
   end

   // Compare each 4-bit component against the layer
   assign col_wide = 32'(rd_col_ff);
   assign row_wide = 32'(rd_row_ff);
   assign word = {
      4'b0000,
      rd_layer_ff,
      row_wide[rgbpwm_pkg::ROW_IDX_W-1:0],
      col_wide[rgbpwm_pkg::COLUMN_IDX_W-1:0],
      lo_color[11:8] > rd_layer_ff,
      lo_color[7:4]  > rd_layer_ff,
      lo_color[3:0]  > rd_layer_ff,
      up_color[11:8] > rd_layer_ff,
      up_color[7:4]  > rd_layer_ff,
      up_color[3:0]  > rd_layer_ff
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         layer_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         layer_ff     <= layer_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_issue) begin
         rd_col_ff   <= col_ff;
         rd_row_ff   <= row_ff;
         rd_layer_ff <= layer_ff;
         rd_last_ff  <= (col_ff == rgbpwm_pkg::COL_LAST);
      end
      if (advance && rd_valid_ff) begin
         out_data_ff <= word;
         out_last_ff <= rd_last_ff;
      end
   end

   assign status.clear_last = &clr_addr_ff;
   assign status.slot_free  = slot_free;
   assign status.col_last   = (col_ff == rgbpwm_pkg::COL_LAST);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
